// ===== rtl/assert_macros.svh =====
// assertion macros for the checker file fcpp_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define FCPP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcpp same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define FCPP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fcpp next-cycle check failed");

`endif

// ===== rtl/fcpp_pkg.sv =====
// shared types and constants for the framed channel packet parser
// no dependencies
package fcpp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned ChanW    = 16;
  localparam int unsigned NumChan  = 6;
  localparam int unsigned PayLen   = 12;
  localparam int unsigned StepW    = 5;
  localparam int unsigned CfgIdxW  = 3;

  // parser step codes
  localparam logic [StepW-1:0] StepIdle   = 5'd0;
  localparam logic [StepW-1:0] StepSync2  = 5'd1;
  localparam logic [StepW-1:0] StepLen    = 5'd2;
  localparam logic [StepW-1:0] StepMode   = 5'd3;
  localparam logic [StepW-1:0] StepPay0   = 5'd4;
  localparam logic [StepW-1:0] StepPay11  = 5'd15;
  localparam logic [StepW-1:0] StepTail1  = 5'd16;
  localparam logic [StepW-1:0] StepTail2  = 5'd17;
  localparam logic [StepW-1:0] StepCommit = 5'd18;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegSyncFirst  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSyncSecond = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLength     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTailFirst  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTailSecond = 3'd4;

  // configuration reset values
  localparam logic [ByteW-1:0] SyncFirstRst  = 8'hA5;
  localparam logic [ByteW-1:0] SyncSecondRst = 8'h5A;
  localparam logic [ByteW-1:0] LengthRst     = 8'd17;
  localparam logic [ByteW-1:0] TailFirstRst  = 8'h12;
  localparam logic [ByteW-1:0] TailSecondRst = 8'h34;

  typedef struct packed {
    logic [ByteW-1:0] sync_first;
    logic [ByteW-1:0] sync_second;
    logic [ByteW-1:0] length_value;
    logic [ByteW-1:0] tail_first;
    logic [ByteW-1:0] tail_second;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0]              mode_value;
    logic [NumChan-1:0][ChanW-1:0] chan;
    logic                          frame_done;
  } result_t;

endpackage

// ===== rtl/fcpp_parser.sv =====
// frame parser: step register, payload bytes, mode and committed channels
// depends on fcpp_pkg
module fcpp_parser import fcpp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] rx_byte_i,
  input  cfg_t             cfg_i,
  output result_t          result_o
);

  logic [StepW-1:0]              step_q, step_d;
  logic [ByteW-1:0]              mode_q, mode_d;
  logic [NumChan-1:0][ChanW-1:0] chan_q, chan_d;
  logic [ByteW-1:0]              pay_q [PayLen];
  logic [StepW-1:0]              pay_off;
  logic                          pay_we;
  logic                          commit;

  assign pay_off = step_q - StepPay0;
  assign pay_we  = accept_i && (step_q >= StepPay0) && (step_q <= StepPay11);

  always_comb begin
    step_d = StepIdle;
    mode_d = mode_q;
    commit = 1'b0;
    case (step_q)
      StepIdle:   step_d = (rx_byte_i == cfg_i.sync_first)   ? StepSync2 : StepIdle;
      StepSync2:  step_d = (rx_byte_i == cfg_i.sync_second)  ? StepLen   : StepIdle;
      StepLen:    step_d = (rx_byte_i == cfg_i.length_value) ? StepMode  : StepIdle;
      StepMode: begin
        mode_d = rx_byte_i;
        step_d = StepPay0;
      end
      StepTail1:  step_d = (rx_byte_i == cfg_i.tail_first)   ? StepTail2  : StepIdle;
      StepTail2:  step_d = (rx_byte_i == cfg_i.tail_second)  ? StepCommit : StepIdle;
      StepCommit: begin
        commit = 1'b1;
        step_d = StepIdle;
      end
      default: begin
        if ((step_q >= StepPay0) && (step_q <= StepPay11)) begin
          step_d = step_q + 5'd1;
        end
      end
    endcase
  end

  // channel k takes payload bytes 2k and 2k+1, high byte first
  always_comb begin
    chan_d = chan_q;
    if (commit) begin
      for (int k = 0; k < NumChan; k++) begin
        chan_d[k] = {pay_q[2*k], pay_q[2*k+1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepIdle;
      mode_q <= '0;
      chan_q <= '0;
    end else if (accept_i) begin
      step_q <= step_d;
      mode_q <= mode_d;
      chan_q <= chan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pay_we) begin
      pay_q[pay_off[3:0]] <= rx_byte_i;
    end
  end

  // result of the byte in flight, values after its update
  assign result_o.mode_value = mode_d;
  assign result_o.chan       = chan_d;
  assign result_o.frame_done = commit;

endmodule

// ===== rtl/fcpp_out_buf.sv =====
// result register with one skid entry between parser and output channel
// depends on fcpp_pkg
module fcpp_out_buf import fcpp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  result_t in_data_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    out_free, accept;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || accept;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  // skid holds the older word, so it drains first
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : in_data_i;
    end else if (accept) begin
      skid_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/framed_channel_packet_parser.sv =====
// top level of the framed channel packet parser: config registers, parser, output buffer
// depends on fcpp_pkg, fcpp_parser, fcpp_out_buf
//
// Input channel carries one received byte per word (rx_byte_i, in_valid_i/in_stall_o).
// Output channel gives one word per input byte: current mode, six committed
// 16-bit channels and frame_done, set on the byte that follows a good trailer.
// Frame: sync_first, sync_second, length, mode, 12 payload bytes, two trailer
// bytes, one discarded byte on which the channels are committed.
// Each accepted byte's word is registered in the result register, or in the skid
// entry while a stall holds it. Throughput is one byte per cycle while in_stall_o
// is low, set by the single step register updated on every accepted byte. The skid
// entry lets the input keep flowing for one more word while the receiver stalls; with
// both full, in_stall_o rises until the receiver takes a word.
// Indexes beyond the last config register are ignored. The user must write config
// registers via cfg_we_i/cfg_index_i/cfg_data_i only while idle; it is not enforced.
// Reset puts the parser in the wait-for-sync step, clears mode and channels,
// restores the default sync, length and trailer values and empties the buffer.
module framed_channel_packet_parser import fcpp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ByteW-1:0]   rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ByteW-1:0]   mode_value_o,
  output logic [ChanW-1:0]   chan_one_o,
  output logic [ChanW-1:0]   chan_two_o,
  output logic [ChanW-1:0]   chan_three_o,
  output logic [ChanW-1:0]   chan_four_o,
  output logic [ChanW-1:0]   chan_five_o,
  output logic [ChanW-1:0]   chan_six_o,
  output logic               frame_done_o
);

  cfg_t    cfg_q;
  result_t result, out_data;
  logic    accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first   <= SyncFirstRst;
      cfg_q.sync_second  <= SyncSecondRst;
      cfg_q.length_value <= LengthRst;
      cfg_q.tail_first   <= TailFirstRst;
      cfg_q.tail_second  <= TailSecondRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegSyncFirst:  cfg_q.sync_first   <= cfg_data_i;
        RegSyncSecond: cfg_q.sync_second  <= cfg_data_i;
        RegLength:     cfg_q.length_value <= cfg_data_i;
        RegTailFirst:  cfg_q.tail_first   <= cfg_data_i;
        RegTailSecond: cfg_q.tail_second  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept = in_valid_i && !in_stall_o;

  fcpp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .cfg_i     (cfg_q),
    .result_o  (result)
  );

  fcpp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (result),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign mode_value_o = out_data.mode_value;
  assign chan_one_o   = out_data.chan[0];
  assign chan_two_o   = out_data.chan[1];
  assign chan_three_o = out_data.chan[2];
  assign chan_four_o  = out_data.chan[3];
  assign chan_five_o  = out_data.chan[4];
  assign chan_six_o   = out_data.chan[5];
  assign frame_done_o = out_data.frame_done;

endmodule

// ===== rtl/fcpp_checker.sv =====
// port-level checks for the framed channel packet parser, bound to the top level
// depends on fcpp_pkg and assert_macros.svh
`include "assert_macros.svh"

module fcpp_checker import fcpp_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [ByteW-1:0]   mode_value_o,
  input logic [ChanW-1:0]   chan_one_o,
  input logic [ChanW-1:0]   chan_two_o,
  input logic [ChanW-1:0]   chan_three_o,
  input logic [ChanW-1:0]   chan_four_o,
  input logic [ChanW-1:0]   chan_five_o,
  input logic [ChanW-1:0]   chan_six_o,
  input logic               frame_done_o
);

  logic [ByteW+NumChan*ChanW:0] out_word;
  logic                         out_held;

  assign out_word = {mode_value_o, chan_one_o, chan_two_o, chan_three_o,
                     chan_four_o, chan_five_o, chan_six_o, frame_done_o};
  assign out_held = out_valid_o && out_stall_i;

  // a stalled result word holds
  `FCPP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_word))

  // input backpressure only when the result register is full as well
  `FCPP_ASSERT_IMP(a_stall_full, clk_i, rst_ni, in_stall_o, out_valid_o)

  // an accepted byte with an empty output shows up in the next cycle
  `FCPP_ASSERT_NXT(a_one_cycle, clk_i, rst_ni, in_valid_i && !in_stall_o && !out_valid_o, out_valid_o)

  // a taken result always frees the skid entry
  `FCPP_ASSERT_NXT(a_skid_drain, clk_i, rst_ni, out_valid_o && !out_stall_i, !in_stall_o)

endmodule

bind framed_channel_packet_parser fcpp_checker u_fcpp_checker (.*);

// ===== tb/tb_framed_channel_packet_parser.sv =====
`timescale 1ns / 100ps
// self-checking testbench for framed_channel_packet_parser: directed table, then framed random traffic
// depends on fcpp_pkg and the framed_channel_packet_parser rtl
module tb_framed_channel_packet_parser;
  import fcpp_pkg::*;

  localparam int WatchdogLimit = 1000;
  localparam int HoldCycles    = 200;
  localparam int BytesPerPhase = 340;
  localparam int MaxShown      = 10;
  localparam int DirRows       = 26;
  localparam int FrameBytes    = 19;
  localparam logic [CfgIdxW-1:0] RegPastEnd = 3'd7;

  typedef struct packed {
    logic [ByteW-1:0] rx;
    logic             known;
    logic [ByteW-1:0] mode;
    logic [ChanW-1:0] chan;
    logic             done;
  } dir_row_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [ByteW-1:0]   cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [ByteW-1:0]   rx_byte_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [ByteW-1:0]   mode_value_o;
  logic [ChanW-1:0]   chan_one_o, chan_two_o, chan_three_o;
  logic [ChanW-1:0]   chan_four_o, chan_five_o, chan_six_o;
  logic               frame_done_o;

  framed_channel_packet_parser dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .mode_value_o (mode_value_o),
    .chan_one_o   (chan_one_o),
    .chan_two_o   (chan_two_o),
    .chan_three_o (chan_three_o),
    .chan_four_o  (chan_four_o),
    .chan_five_o  (chan_five_o),
    .chan_six_o   (chan_six_o),
    .frame_done_o (frame_done_o)
  );

  always #5 clk_i = ~clk_i;

  // directed frame: sync2 mismatch, stray second sync, bad length, then a full frame
  // of 0xff whose commit byte is a sync byte that must be lost
  dir_row_t dir_rows [DirRows] = '{
    '{SyncFirstRst,  1'b1, 8'h00, 16'h0000, 1'b0},
    '{SyncFirstRst,  1'b1, 8'h00, 16'h0000, 1'b0},
    '{SyncSecondRst, 1'b1, 8'h00, 16'h0000, 1'b0},
    '{SyncFirstRst,  1'b1, 8'h00, 16'h0000, 1'b0},
    '{SyncSecondRst, 1'b1, 8'h00, 16'h0000, 1'b0},
    '{8'h10,         1'b1, 8'h00, 16'h0000, 1'b0},
    '{SyncFirstRst,  1'b1, 8'h00, 16'h0000, 1'b0},
    '{SyncSecondRst, 1'b1, 8'h00, 16'h0000, 1'b0},
    '{LengthRst,     1'b1, 8'h00, 16'h0000, 1'b0},
    '{8'hFF,         1'b1, 8'hFF, 16'h0000, 1'b0},
    '{8'hFF,         1'b0, 8'hFF, 16'h0000, 1'b0},
    '{8'hFF,         1'b0, 8'hFF, 16'h0000, 1'b0},
    '{8'hFF,         1'b0, 8'hFF, 16'h0000, 1'b0},
    '{8'hFF,         1'b0, 8'hFF, 16'h0000, 1'b0},
    '{8'hFF,         1'b0, 8'hFF, 16'h0000, 1'b0},
    '{8'hFF,         1'b0, 8'hFF, 16'h0000, 1'b0},
    '{8'hFF,         1'b0, 8'hFF, 16'h0000, 1'b0},
    '{8'hFF,         1'b0, 8'hFF, 16'h0000, 1'b0},
    '{8'hFF,         1'b0, 8'hFF, 16'h0000, 1'b0},
    '{8'hFF,         1'b0, 8'hFF, 16'h0000, 1'b0},
    '{8'hFF,         1'b0, 8'hFF, 16'h0000, 1'b0},
    '{8'hFF,         1'b0, 8'hFF, 16'h0000, 1'b0},
    '{TailFirstRst,  1'b1, 8'hFF, 16'h0000, 1'b0},
    '{TailSecondRst, 1'b1, 8'hFF, 16'h0000, 1'b0},
    '{SyncFirstRst,  1'b1, 8'hFF, 16'hFFFF, 1'b1},
    '{SyncSecondRst, 1'b1, 8'hFF, 16'hFFFF, 1'b0}
  };

  // parser shadow state and register copy
  cfg_t                          cfg_shadow;
  logic [StepW-1:0]              p_step;
  logic [ByteW-1:0]              p_payload [PayLen];
  logic [ByteW-1:0]              p_mode;
  logic [NumChan-1:0][ChanW-1:0] p_chans;

  result_t pending_words [$];
  int      bytes_sent;
  int      words_seen;
  int      mismatches;
  int      stuck_cycles;
  bit      quiet;
  bit      hold_req;
  int      hold_left;
  result_t want_w, got_w;
  bit      word_bad;

  function automatic result_t parse_byte(input logic [ByteW-1:0] b);
    result_t r;
    int      k;
    r.frame_done = 1'b0;
    if (p_step == StepIdle) begin
      p_step = (b == cfg_shadow.sync_first) ? StepSync2 : StepIdle;
    end else if (p_step == StepSync2) begin
      p_step = (b == cfg_shadow.sync_second) ? StepLen : StepIdle;
    end else if (p_step == StepLen) begin
      p_step = (b == cfg_shadow.length_value) ? StepMode : StepIdle;
    end else if (p_step == StepMode) begin
      p_mode = b;
      p_step = StepPay0;
    end else if (p_step >= StepPay0 && p_step <= StepPay11) begin
      p_payload[p_step - StepPay0] = b;
      p_step = p_step + 1'b1;
    end else if (p_step == StepTail1) begin
      p_step = (b == cfg_shadow.tail_first) ? StepTail2 : StepIdle;
    end else if (p_step == StepTail2) begin
      p_step = (b == cfg_shadow.tail_second) ? StepCommit : StepIdle;
    end else if (p_step == StepCommit) begin
      // byte itself is dropped, channels come from the stored payload
      for (k = 0; k < NumChan; k++) begin
        p_chans[k] = {p_payload[2*k], p_payload[2*k+1]};
      end
      r.frame_done = 1'b1;
      p_step = StepIdle;
    end else begin
      p_step = StepIdle;
    end
    r.mode_value = p_mode;
    r.chan       = p_chans;
    return r;
  endfunction

  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return ByteW'($urandom_range(255));
    endcase
  endfunction

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      RegSyncFirst:  cfg_shadow.sync_first   = val;
      RegSyncSecond: cfg_shadow.sync_second  = val;
      RegLength:     cfg_shadow.length_value = val;
      RegTailFirst:  cfg_shadow.tail_first   = val;
      RegTailSecond: cfg_shadow.tail_second  = val;
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [ByteW-1:0] s1, s2, len, t1, t2);
    cfg_write(RegSyncFirst, s1);
    cfg_write(RegSyncSecond, s2);
    cfg_write(RegLength, len);
    cfg_write(RegTailFirst, t1);
    cfg_write(RegTailSecond, t2);
    // unmapped index must leave everything alone
    cfg_write(RegPastEnd, ~s1);
    cfg_we_i <= 1'b0;
  endtask

  // leaves valid high on return; the caller sends again or drains in the same step
  task automatic send_byte(input logic [ByteW-1:0] b, input bit use_typed = 1'b0,
                           input result_t typed = '0);
    bit      ok;
    result_t w;
    if (!quiet && $urandom_range(99) < 25) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 25);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do begin
      @(negedge clk_i);
      ok = !in_stall_o;
      @(posedge clk_i);
    end while (!ok);
    w = parse_byte(b);
    pending_words.push_back(use_typed ? typed : w);
    bytes_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // mostly well-formed frames with random content, some broken, the rest noise
  task automatic run_traffic(input int count);
    int               stop;
    int               k;
    logic [StepW-1:0] flaw_at;
    logic [ByteW-1:0] fb [FrameBytes];
    stop = bytes_sent + count;
    while (bytes_sent < stop) begin
      if ($urandom_range(99) < 70) begin
        fb[StepIdle]  = cfg_shadow.sync_first;
        fb[StepSync2] = cfg_shadow.sync_second;
        fb[StepLen]   = cfg_shadow.length_value;
        fb[StepMode]  = pick_byte();
        for (k = StepPay0; k <= StepPay11; k++) fb[k] = pick_byte();
        fb[StepTail1]  = cfg_shadow.tail_first;
        fb[StepTail2]  = cfg_shadow.tail_second;
        fb[StepCommit] = $urandom_range(1) ? cfg_shadow.sync_first : pick_byte();
        if ($urandom_range(99) < 20) begin
          case ($urandom_range(3))
            0:       flaw_at = StepSync2;
            1:       flaw_at = StepLen;
            2:       flaw_at = StepTail1;
            default: flaw_at = StepTail2;
          endcase
          fb[flaw_at] = fb[flaw_at] ^ 8'($urandom_range(1, 255));
        end
        for (k = 0; k < FrameBytes; k++) send_byte(fb[k]);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_byte(($urandom_range(3) == 0) ? cfg_shadow.sync_first : pick_byte());
        end
      end
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_req) begin
      out_stall_i <= 1'b1;
      hold_left = HoldCycles;
      hold_req = 1'b0;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(99) < 25);
    end
  end

  // output words are checked at the falling clock edge, before the edge that takes them
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_w.mode_value = mode_value_o;
      got_w.chan       = {chan_six_o, chan_five_o, chan_four_o,
                          chan_three_o, chan_two_o, chan_one_o};
      got_w.frame_done = frame_done_o;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown) begin
          $display("word %0d: output word with nothing expected, mode %h done %b",
                   words_seen, got_w.mode_value, got_w.frame_done);
        end
      end else begin
        want_w = pending_words.pop_front();
        word_bad = (got_w.mode_value !== want_w.mode_value) ||
                   (got_w.frame_done !== want_w.frame_done);
        for (int k = 0; k < NumChan; k++) begin
          if (got_w.chan[k] !== want_w.chan[k]) word_bad = 1'b1;
        end
        if (word_bad) begin
          mismatches++;
          if (mismatches <= MaxShown) begin
            $display("word %0d mismatch", words_seen);
            $display("  expected mode %h chan %h %h %h %h %h %h done %b",
                     want_w.mode_value, want_w.chan[0], want_w.chan[1], want_w.chan[2],
                     want_w.chan[3], want_w.chan[4], want_w.chan[5], want_w.frame_done);
            $display("  actual   mode %h chan %h %h %h %h %h %h done %b",
                     got_w.mode_value, got_w.chan[0], got_w.chan[1], got_w.chan[2],
                     got_w.chan[3], got_w.chan[4], got_w.chan[5], got_w.frame_done);
          end
        end
      end
      words_seen++;
    end
  end

  // watchdog on cycles where neither side moves a word
  always @(negedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= WatchdogLimit) begin
      $display("tb_framed_channel_packet_parser: done, errors");
      $finish;
    end
  end

  initial begin
    result_t tw;
    cfg_shadow.sync_first   = SyncFirstRst;
    cfg_shadow.sync_second  = SyncSecondRst;
    cfg_shadow.length_value = LengthRst;
    cfg_shadow.tail_first   = TailFirstRst;
    cfg_shadow.tail_second  = TailSecondRst;
    p_step  = StepIdle;
    p_mode  = '0;
    p_chans = '0;
    for (int k = 0; k < PayLen; k++) p_payload[k] = '0;
    bytes_sent   = 0;
    words_seen   = 0;
    mismatches   = 0;
    stuck_cycles = 0;
    quiet        = 1'b0;
    hold_req     = 1'b0;
    hold_left    = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirRows; i++) begin
      tw.mode_value = dir_rows[i].mode;
      tw.chan       = {NumChan{dir_rows[i].chan}};
      tw.frame_done = dir_rows[i].done;
      send_byte(dir_rows[i].rx, dir_rows[i].known, tw);
    end
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: load_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        1: load_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        4: load_config(SyncFirstRst, SyncSecondRst, LengthRst, TailFirstRst, TailSecondRst);
        default: load_config(ByteW'($urandom_range(255)), ByteW'($urandom_range(255)),
                             ByteW'($urandom_range(255)), ByteW'($urandom_range(255)),
                             ByteW'($urandom_range(255)));
      endcase
      quiet = (phase == 2) || (phase == 3);
      if (phase == 3) begin
        // sender keeps offering while the receiver holds off, so the input backs up
        hold_req = 1'b1;
        run_traffic(120);
        quiet = 1'b0;
        run_traffic(BytesPerPhase - 120);
      end else begin
        run_traffic(BytesPerPhase);
      end
      drain();
    end
    quiet = 1'b0;

    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("tb_framed_channel_packet_parser: done, clean");
    end else begin
      $display("tb_framed_channel_packet_parser: done, errors");
    end
    $finish;
  end

endmodule
